[design/bcba_pkg.sv]
package bcba_pkg;

    // map geometry
    localparam int MAX_BLOCKS = 1024;
    localparam int WORD_W     = 32;
    localparam int WORDS      = MAX_BLOCKS / WORD_W;
    localparam int WA_W       = $clog2(WORDS);
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int PP_W       = BIT_W + 1;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int RUN_W      = CNT_W + 1;

    // register and field widths
    localparam int NB_W       = 11;
    localparam int BS_W       = 13;
    localparam int MAPB_W     = 8;
    localparam int ST_W       = 2;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // map sizing: bits per byte, divider width
    localparam int BYTE_BITS  = 8;
    localparam int DIV_W      = BS_W + 1;
    localparam int DIVC_W     = $clog2(DIV_W);

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [NB_W-1:0] NB_RESET = NB_W'(1024);
    localparam logic [BS_W-1:0] BS_RESET = BS_W'(512);

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_RMW,
        S_QRY,
        S_OUT
    } t_state;

endpackage

[design/bcba_div.sv]
module bcba_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bcba_pkg::DIV_W-1:0] i_dividend,
    input  logic [bcba_pkg::BS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [bcba_pkg::DIV_W-1:0] o_quot
);
    import bcba_pkg::*;

    // restoring divider, one quotient bit per cycle
    logic              r_busy;
    logic              r_done;
    logic [DIVC_W-1:0] r_step;
    logic [BS_W-1:0]   r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [BS_W-1:0]   r_dvs;

    logic [BS_W:0]     rem_sh;
    logic [BS_W:0]     rem_diff;
    logic              ge;

    always_comb begin
        rem_sh   = {r_rem, r_quo[DIV_W-1]};
        ge       = (rem_sh >= {1'b0, r_dvs});
        rem_diff = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == DIVC_W'(DIV_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_step <= r_step + DIVC_W'(1);
            r_rem  <= ge ? rem_diff[BS_W-1:0] : rem_sh[BS_W-1:0];
            r_quo  <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

[design/bitmap_contiguous_block_allocator_core.sv]
// Channel   Dir  Handshake                         Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready   tuser: operation; tdata: index, count
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready   tuser: status; tdata: start, bit, map size
// cfg       in   i_cfg_valid/o_cfg_ready           i_cfg_index, i_cfg_data
//
// The map is a 32 x 32-bit simple dual-port memory; every operation walks it one word per
// cycle, so the time per beat follows the number of words touched: query reads one word,
// free its range, allocate the scanned words and then the marked words, init the marked
// words after a 14-step serial divide for the map size.
// Reset (synchronous, active low) clears the per-word valid bits, so the whole map
// reads free at once; no clearing pass. s_axis is ready only between operations; one
// finished result may wait in the output register while the next beat is taken.
module bitmap_contiguous_block_allocator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [9:0] block_index, [20:10] block_count, [23:21] zero
    input  logic [bcba_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // [1:0] operation
    input  logic [bcba_pkg::OP_W-1:0]            i_s_axis_tuser,

    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [9:0] start_block, [10] bit_value, [18:11] map_blocks, [23:19] zero
    output logic [bcba_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // [1:0] status
    output logic [bcba_pkg::ST_W-1:0]            o_m_axis_tuser,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bcba_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bcba_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bcba_pkg::*;

    // ---------------- registers ----------------
    t_state              r_state, n_state;
    logic [NB_W-1:0]     r_nb;
    logic [BS_W-1:0]     r_bs;

    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    // word walker: read address side and evaluate side
    logic [WA_W-1:0]     r_raddr, n_raddr;
    logic [WA_W-1:0]     r_rlast, n_rlast;
    logic                r_rmore, n_rmore;
    logic                r_evld, n_evld;
    logic [WA_W-1:0]     r_ewd, n_ewd;

    logic [CNT_W-1:0]    r_run, n_run;   // free run carried across words
    logic [CNT_W-1:0]    r_lo, n_lo;     // range being marked or cleared
    logic [CNT_W-1:0]    r_hi, n_hi;
    logic                r_set, n_set;

    t_status             r_res_st, n_res_st;
    logic [IDX_W-1:0]    r_res_start, n_res_start;
    logic                r_res_bit, n_res_bit;
    logic [MAPB_W-1:0]   r_res_mapb, n_res_mapb;

    logic                r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [ST_W-1:0]     r_out_user;

    // map memory plus per-word valid bits (invalid word reads all free)
    logic [WORD_W-1:0]   mem [WORDS];
    logic [WORDS-1:0]    r_vld;
    logic [WORD_W-1:0]   r_rdata;
    logic                r_rvld;

    // ---------------- combinational ----------------
    t_op                 in_op;
    logic [IDX_W-1:0]    in_idx;
    logic [CNT_W-1:0]    in_cnt;
    logic                in_acc;
    logic [CNT_W-1:0]    n_eff;
    logic [CNT_W:0]      in_end;
    logic                free_bad;
    logic                qry_bad;

    logic [CNT_W:0]      n_plus;
    logic [CNT_W:0]      bytes;
    logic [BS_W-1:0]     bs_eff;
    logic [DIV_W-1:0]    div_dividend;
    logic                div_start;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;

    logic [WORD_W-1:0]   rword;
    logic [WORD_W-1:0]   free_v;
    logic [WORD_W-1:0]   hit_v;
    logic [WORD_W-1:0]   mask_v;
    logic [RUN_W-1:0]    run_v [WORD_W];
    logic [BIT_W-1:0]    hj;
    logic                any_hit;
    logic [CNT_W-1:0]    hit_hi;
    logic [CNT_W-1:0]    hit_lo;
    logic [CNT_W-1:0]    free_hi;
    logic [CNT_W-1:0]    n_last;
    logic [WORD_W-1:0]   merged;

    logic                rd_en;
    logic                wr_en;
    logic                vld_clr;
    logic                out_load;

    assign in_op  = t_op'(i_s_axis_tuser);
    assign in_idx = i_s_axis_tdata[IDX_W-1:0];
    assign in_cnt = i_s_axis_tdata[IDX_W +: CNT_W];
    assign in_acc = i_s_axis_tvalid && (r_state == S_IDLE);

    // block count saturated at the map depth
    assign n_eff = (r_nb > NB_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(r_nb);
    assign n_last = n_eff - CNT_W'(1);

    assign in_end   = {1'b0, 1'b0, in_idx} + {1'b0, in_cnt};
    assign free_bad = (in_idx == '0) || (in_end > {1'b0, n_eff});
    assign qry_bad  = ({1'b0, in_idx} >= n_eff);
    assign free_hi  = {1'b0, in_idx} + in_cnt - CNT_W'(1);

    // map size = ceil(ceil(n / 8) / block_size), zero block size taken as one
    assign n_plus       = {1'b0, n_eff} + (CNT_W+1)'(BYTE_BITS - 1);
    assign bytes        = n_plus >> $clog2(BYTE_BITS);
    assign bs_eff       = (r_bs == '0) ? BS_W'(1) : r_bs;
    assign div_dividend = DIV_W'(bytes) + DIV_W'(bs_eff) - DIV_W'(1);

    bcba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (bs_eff),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign rword = r_rvld ? r_rdata : '0;

    // per-word run search: run length ending at each bit, first bit reaching the count
    always_comb begin
        logic [PP_W-1:0] pp;
        for (int j = 0; j < WORD_W; j++) begin
            free_v[j] = !rword[j] && ({1'b0, r_ewd, BIT_W'(j)} < n_eff);
            mask_v[j] = ({1'b0, r_ewd, BIT_W'(j)} >= r_lo) &&
                        ({1'b0, r_ewd, BIT_W'(j)} <= r_hi);
        end
        for (int j = 0; j < WORD_W; j++) begin
            pp = '0;
            // last used bit at or below j, plus one; zero when the word is free up to j
            for (int k = 0; k <= j; k++) begin
                if (!free_v[k]) begin
                    pp = PP_W'(k + 1);
                end
            end
            run_v[j] = (pp == '0) ? (RUN_W'(r_run) + RUN_W'(j + 1))
                                  : (RUN_W'(j + 1) - RUN_W'(pp));
            hit_v[j] = free_v[j] && (run_v[j] >= RUN_W'(r_cnt));
        end
        hj = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (hit_v[j]) begin
                hj = BIT_W'(j);
            end
        end
    end

    assign any_hit = |hit_v;
    assign hit_hi  = {1'b0, r_ewd, hj};
    assign hit_lo  = hit_hi + CNT_W'(1) - r_cnt;
    assign merged  = r_set ? (rword | mask_v) : (rword & ~mask_v);

    assign rd_en    = r_rmore;
    assign wr_en    = (r_state == S_RMW) && r_evld;
    assign vld_clr  = in_acc && (in_op == OP_INIT);
    assign div_start = vld_clr;
    assign out_load = (r_state == S_OUT) && (!r_out_vld || i_m_axis_tready);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_op)
                        OP_INIT:  n_state = S_DIV;
                        OP_ALLOC: n_state = ((in_cnt == '0) || (n_eff == '0)) ? S_OUT : S_SCAN;
                        OP_FREE:  n_state = (free_bad || (in_cnt == '0)) ? S_OUT : S_RMW;
                        OP_QUERY: n_state = qry_bad ? S_OUT : S_QRY;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_RMW;
                end
            end
            S_SCAN: begin
                if (r_evld) begin
                    if (any_hit) begin
                        n_state = S_RMW;
                    end else if (r_ewd == r_rlast) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_RMW: begin
                if (r_evld && (r_ewd == r_rlast)) begin
                    n_state = S_OUT;
                end
            end
            S_QRY: begin
                if (r_evld) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath next values ----------------
    always_comb begin
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_raddr     = r_raddr;
        n_rlast     = r_rlast;
        n_rmore     = r_rmore;
        n_evld      = rd_en;
        n_ewd       = r_raddr;
        n_run       = r_run;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_set       = r_set;
        n_res_st    = r_res_st;
        n_res_start = r_res_start;
        n_res_bit   = r_res_bit;
        n_res_mapb  = r_res_mapb;

        // read side walks toward the last word
        if (r_rmore) begin
            if (r_raddr == r_rlast) begin
                n_rmore = 1'b0;
            end else begin
                n_raddr = r_raddr + WA_W'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx       = in_idx;
                    n_cnt       = in_cnt;
                    n_run       = '0;
                    n_res_st    = ST_OK;
                    n_res_start = '0;
                    n_res_bit   = 1'b0;
                    n_res_mapb  = '0;
                    case (in_op)
                        OP_INIT: begin
                            n_set = 1'b1;
                        end
                        OP_ALLOC: begin
                            if ((in_cnt == '0) || (n_eff == '0)) begin
                                n_res_st = ST_NOFIT;
                            end else begin
                                n_raddr = '0;
                                n_rlast = n_last[BIT_W +: WA_W];
                                n_rmore = 1'b1;
                            end
                        end
                        OP_FREE: begin
                            if (free_bad) begin
                                n_res_st = ST_BAD;
                            end else if (in_cnt != '0) begin
                                n_lo    = {1'b0, in_idx};
                                n_hi    = free_hi;
                                n_set   = 1'b0;
                                n_raddr = in_idx[BIT_W +: WA_W];
                                n_rlast = free_hi[BIT_W +: WA_W];
                                n_rmore = 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            if (qry_bad) begin
                                n_res_st = ST_BAD;
                            end else begin
                                n_raddr = in_idx[BIT_W +: WA_W];
                                n_rlast = in_idx[BIT_W +: WA_W];
                                n_rmore = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    // mark block 0 through the map's own blocks
                    n_res_mapb = div_q[MAPB_W-1:0];
                    n_lo       = '0;
                    n_hi       = CNT_W'(div_q);
                    n_raddr    = '0;
                    n_rlast    = div_q[BIT_W +: WA_W];
                    n_rmore    = 1'b1;
                end
            end
            S_SCAN: begin
                if (r_evld) begin
                    if (any_hit) begin
                        n_res_start = hit_lo[IDX_W-1:0];
                        n_lo        = hit_lo;
                        n_hi        = hit_hi;
                        n_set       = 1'b1;
                        n_raddr     = hit_lo[BIT_W +: WA_W];
                        n_rlast     = r_ewd;
                        n_rmore     = 1'b1;
                        n_evld      = 1'b0;   // drop the read in flight
                    end else begin
                        n_run = CNT_W'(run_v[WORD_W-1]);
                        if (r_ewd == r_rlast) begin
                            n_res_st = ST_NOFIT;
                        end
                    end
                end
            end
            S_QRY: begin
                if (r_evld) begin
                    n_res_bit = rword[r_idx[BIT_W-1:0]];
                end
            end
            default: ;
        endcase
    end

    // ---------------- sequential ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rmore   <= 1'b0;
            r_evld    <= 1'b0;
            r_nb      <= NB_RESET;
            r_bs      <= BS_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rmore <= n_rmore;
            r_evld  <= n_evld;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_NUM_BLOCKS: r_nb <= i_cfg_data[NB_W-1:0];
                    CFG_BLOCK_SIZE: r_bs <= i_cfg_data[BS_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_cnt       <= n_cnt;
        r_raddr     <= n_raddr;
        r_rlast     <= n_rlast;
        r_ewd       <= n_ewd;
        r_run       <= n_run;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_set       <= n_set;
        r_res_st    <= n_res_st;
        r_res_start <= n_res_start;
        r_res_bit   <= n_res_bit;
        r_res_mapb  <= n_res_mapb;
        if (out_load) begin
            r_out_data <= OUT_TDATA_W'({r_res_mapb, r_res_bit, r_res_start});
            r_out_user <= r_res_st;
        end
    end

    // word valid bits: reset and init clear all, any write sets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (vld_clr) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_ewd] <= 1'b1;
        end
    end

    // map memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_ewd] <= merged;
        end
        if (rd_en) begin
            r_rdata <= mem[r_raddr];
            r_rvld  <= r_vld[r_raddr];
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_cfg_ready     = 1'b1;

endmodule

[tb/tb.sv]
module tb;
    import bcba_pkg::*;

    localparam int N_DIR          = 23;
    localparam int N_PHASES       = 9;
    localparam int PHASE_ITEMS    = 105;
    localparam int CFG_SETTLE     = 80;    // longer than the slowest allocate
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 3000;  // idle cycles, well above hold-off + allocate

    // one reply of the allocator, field order as in the result item
    typedef struct packed {
        t_status            st;
        logic [IDX_W-1:0]   start;
        logic               bitv;
        logic [MAPB_W-1:0]  mapb;
    } map_reply_t;

    // directed row; chk marks rows whose reply is typed in here
    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   cnt;
        logic               chk;
        t_status            st;
        logic [IDX_W-1:0]   start;
        logic               bitv;
        logic [MAPB_W-1:0]  mapb;
    } dir_row_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic [OP_W-1:0]         i_s_axis_tuser = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic [ST_W-1:0]         o_m_axis_tuser;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    bitmap_contiguous_block_allocator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow allocator: own copy of the map and both registers
    // ------------------------------------------------------------------
    bit [MAX_BLOCKS-1:0]  blk_used = '0;
    logic [NB_W-1:0]      cfg_nblocks = NB_RESET;
    logic [BS_W-1:0]      cfg_bsize = BS_RESET;
    int unsigned          run_start[$];   // runs handed out, used to pick sane frees
    int unsigned          run_len[$];

    map_reply_t           pending_replies[$];

    int n_mismatch   = 0;
    int n_requests   = 0;
    int n_placed     = 0;
    int n_refused    = 0;
    int n_rejected   = 0;
    int n_cfg_writes = 0;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int rx_hold_reqs  = 0;   // bumped by the stimulus, followed by the reply side
    int rx_hold_seen  = 0;

    function automatic int unsigned volume_blocks();
        return (cfg_nblocks > MAX_BLOCKS) ? MAX_BLOCKS : cfg_nblocks;
    endfunction

    // Applies one operation to the shadow map and returns the reply it gives.
    function automatic map_reply_t apply_map_op(t_op op, logic [IDX_W-1:0] idx,
                                                 logic [CNT_W-1:0] cnt);
        map_reply_t  r;
        int unsigned n, bs, map_bytes, mb, run, first, i, ui, uc;
        bit          found;
        r     = '{ST_OK, '0, 1'b0, '0};
        n     = volume_blocks();
        ui    = idx;
        uc    = cnt;
        run   = 0;
        first = 0;
        found = 1'b0;
        case (op)
            OP_INIT: begin
                bs        = (cfg_bsize == 0) ? 1 : cfg_bsize;
                map_bytes = (n + BYTE_BITS - 1) / BYTE_BITS;
                mb        = (map_bytes + bs - 1) / bs;
                blk_used  = '0;
                // block 0 plus the map's own blocks, clipped to the store
                for (i = 0; i <= mb && i < MAX_BLOCKS; i++)
                    blk_used[i] = 1'b1;
                r.mapb = mb[MAPB_W-1:0];
                run_start.delete();
                run_len.delete();
            end
            OP_ALLOC: begin
                if (uc != 0) begin
                    for (i = 0; i < n; i++) begin
                        if (!blk_used[i]) begin
                            if (run == 0)
                                first = i;
                            run++;
                            if (run == uc) begin
                                found = 1'b1;
                                break;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                end
                if (found) begin
                    for (i = first; i < first + uc; i++)
                        blk_used[i] = 1'b1;
                    r.start = first[IDX_W-1:0];
                    run_start.push_back(first);
                    run_len.push_back(uc);
                end else begin
                    r.st = ST_NOFIT;
                end
            end
            OP_FREE: begin
                if (ui < 1 || ui + uc > n) begin
                    r.st = ST_BAD;
                end else begin
                    for (i = ui; i < ui + uc; i++)
                        blk_used[i] = 1'b0;
                end
            end
            default: begin
                if (ui >= n)
                    r.st = ST_BAD;
                else
                    r.bitv = blk_used[ui];
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offers one beat after a random idle gap, waits for the handshake and
    // queues the reply; tvalid stays high when the next beat follows at once.
    task automatic send_req(input t_op op, input logic [IDX_W-1:0] idx,
                            input logic [CNT_W-1:0] cnt, input logic chk,
                            input map_reply_t typed_reply);
        map_reply_t r;
        int         gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {3'b000, cnt, idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = apply_map_op(op, idx, cnt);
        pending_replies.push_back(chk ? typed_reply : r);
        n_requests++;
        if (r.st == ST_NOFIT)
            n_refused++;
        else if (r.st == ST_BAD)
            n_rejected++;
        else if (op == OP_ALLOC)
            n_placed++;
    endtask

    task automatic wait_drained();
        while (pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // Register write; only called with the request channel idle.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] ridx,
                             input logic [CFG_DATA_W-1:0] wdata);
        wait_drained();
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ridx;
        i_cfg_data  <= wdata;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (ridx == CFG_NUM_BLOCKS)
            cfg_nblocks = wdata[NB_W-1:0];
        else
            cfg_bsize = wdata[BS_W-1:0];
        n_cfg_writes++;
    endtask

    // Mostly well-formed traffic: frees tend to return runs that were handed
    // out, so the map keeps cycling instead of filling up for good.
    task automatic random_req(output t_op op, output logic [IDX_W-1:0] idx,
                              output logic [CNT_W-1:0] cnt);
        int unsigned n, lim, pick, k;
        n    = volume_blocks();
        lim  = (n > MAX_BLOCKS - 1) ? MAX_BLOCKS - 1 : n;
        pick = $urandom_range(99);
        idx  = IDX_W'($urandom_range(MAX_BLOCKS - 1));
        cnt  = '0;
        if (pick < 4) begin
            op = OP_INIT;
        end else if (pick < 40) begin
            op = OP_ALLOC;
            case ($urandom_range(9))
                0:       cnt = CNT_W'($urandom_range(2047));
                1:       cnt = CNT_W'($urandom_range(n));
                default: cnt = CNT_W'($urandom_range(1, 12));
            endcase
        end else if (pick < 72) begin
            op = OP_FREE;
            if (run_start.size() != 0 && $urandom_range(3) != 0) begin
                k   = $urandom_range(run_start.size() - 1);
                idx = IDX_W'(run_start[k]);
                cnt = CNT_W'(run_len[k]);
                run_start.delete(k);
                run_len.delete(k);
            end else if ($urandom_range(15) == 0) begin
                // wipe everything past block 0
                idx = IDX_W'(1);
                cnt = CNT_W'((n > 0) ? n - 1 : 0);
            end else begin
                idx = IDX_W'($urandom_range(lim));
                cnt = ($urandom_range(7) == 0) ? CNT_W'($urandom_range(2047))
                                               : CNT_W'($urandom_range(16));
            end
        end else begin
            op = OP_QUERY;
            if ($urandom_range(4) != 0)
                idx = IDX_W'($urandom_range(lim));
        end
    endtask

    // ------------------------------------------------------------------
    // Reply side: ready pattern plus the long hold-off on request
    // ------------------------------------------------------------------
    int rx_hold_left = 0;

    always @(posedge i_clk) begin
        if (rx_hold_reqs != rx_hold_seen) begin
            rx_hold_left = RX_HOLD_CYCLES;
            rx_hold_seen = rx_hold_reqs;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Reply checker: every accepted beat against the oldest expectation.
    always @(posedge i_clk) begin
        map_reply_t exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                $error("reply beat with nothing outstanding: status %0d tdata %h",
                       o_m_axis_tuser, o_m_axis_tdata);
                n_mismatch++;
            end else begin
                exp_r = pending_replies.pop_front();
                if (o_m_axis_tuser !== exp_r.st) begin
                    $error("status: expected %0d, got %0d", exp_r.st, o_m_axis_tuser);
                    n_mismatch++;
                end
                if (o_m_axis_tdata[9:0] !== exp_r.start) begin
                    $error("start_block: expected %0d, got %0d",
                           exp_r.start, o_m_axis_tdata[9:0]);
                    n_mismatch++;
                end
                if (o_m_axis_tdata[10] !== exp_r.bitv) begin
                    $error("bit_value: expected %0d, got %0d",
                           exp_r.bitv, o_m_axis_tdata[10]);
                    n_mismatch++;
                end
                if (o_m_axis_tdata[18:11] !== exp_r.mapb) begin
                    $error("map_blocks: expected %0d, got %0d",
                           exp_r.mapb, o_m_axis_tdata[18:11]);
                    n_mismatch++;
                end
            end
        end
    end

    // Watchdog: cycles in a row with no beat on any channel.
    int idle_run = 0;

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_run = 0;
        end else begin
            idle_run++;
        end
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed opening, default registers (1024 blocks, 512-byte blocks,
    // so init reserves blocks 0 and 1)
    // ------------------------------------------------------------------
    dir_row_t dir_tab [N_DIR] = '{
        '{OP_QUERY,    0,    0, 1'b1, ST_OK,    0, 1'b0, 0},  // fresh map reads free
        '{OP_QUERY, 1023,    0, 1'b1, ST_OK,    0, 1'b0, 0},
        '{OP_INIT,     0,    0, 1'b1, ST_OK,    0, 1'b0, 1},
        '{OP_QUERY,    1,    0, 1'b1, ST_OK,    0, 1'b1, 0},  // map block
        '{OP_QUERY,    2,    0, 1'b1, ST_OK,    0, 1'b0, 0},
        '{OP_ALLOC,    0,    0, 1'b1, ST_NOFIT, 0, 1'b0, 0},  // zero-length request
        '{OP_ALLOC,    0,    1, 1'b1, ST_OK,    2, 1'b0, 0},
        '{OP_ALLOC,    0, 1024, 1'b1, ST_NOFIT, 0, 1'b0, 0},  // only 1021 left
        '{OP_ALLOC,    0, 1021, 1'b1, ST_OK,    3, 1'b0, 0},  // fills the volume
        '{OP_ALLOC,    0,    1, 1'b1, ST_NOFIT, 0, 1'b0, 0},
        '{OP_QUERY, 1023,    0, 1'b1, ST_OK,    0, 1'b1, 0},
        '{OP_FREE,     0,    1, 1'b1, ST_BAD,   0, 1'b0, 0},  // block 0 is protected
        '{OP_FREE,  1023,    2, 1'b1, ST_BAD,   0, 1'b0, 0},  // one past the end
        '{OP_FREE,  1023,    1, 1'b1, ST_OK,    0, 1'b0, 0},  // exactly at the end
        '{OP_FREE,     5,    0, 1'b1, ST_OK,    0, 1'b0, 0},  // empty range
        '{OP_FREE,     1, 1023, 1'b1, ST_OK,    0, 1'b0, 0},
        '{OP_ALLOC,    0, 1023, 1'b1, ST_OK,    1, 1'b0, 0},
        '{OP_FREE,   500,   10, 1'b1, ST_OK,    0, 1'b0, 0},
        '{OP_ALLOC,    0,   11, 1'b1, ST_NOFIT, 0, 1'b0, 0},  // hole one short
        '{OP_ALLOC,    0,   10, 1'b1, ST_OK,  500, 1'b0, 0},  // exact fit
        '{OP_FREE,   600,  300, 1'b0, ST_OK,    0, 1'b0, 0},
        '{OP_ALLOC, 1023, 2047, 1'b1, ST_NOFIT, 0, 1'b0, 0},  // all-ones fields
        '{OP_ALLOC,    0,   37, 1'b0, ST_OK,    0, 1'b0, 0}
    };

    // Register settings per phase: extremes, the zero cases and a count
    // beyond the store; each phase also sets an idling pattern.
    int ph_nb  [N_PHASES] = '{1024,   64,    1, 2047,   0, 300, 1024, 0, 100};
    int ph_bs  [N_PHASES] = '{4096,    1, 8191,    0, 512,  16,    1, 0,   2};
    int ph_src [N_PHASES] = '{   0,   77,    0,    9,   0,  77,    0, 9,   0};
    int ph_snk [N_PHASES] = '{   0,    0,   77,    9,   0,   0,   77, 9,   0};

    initial begin
        t_op                op;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   cnt;
        logic [CFG_DATA_W-1:0] wdata;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIR; k++) begin
            send_req(dir_tab[k].op, dir_tab[k].idx, dir_tab[k].cnt, dir_tab[k].chk,
                     '{dir_tab[k].st, dir_tab[k].start, dir_tab[k].bitv, dir_tab[k].mapb});
        end

        ph_nb[7] = $urandom_range(1, 1024);
        ph_bs[7] = $urandom_range(1, 4096);

        for (int p = 0; p < N_PHASES; p++) begin
            i_s_axis_tvalid <= 1'b0;
            // junk in the unused upper data bits of the block-count write
            wdata        = CFG_DATA_W'(ph_nb[p]);
            wdata[12:11] = 2'($urandom_range(3));
            cfg_write(CFG_NUM_BLOCKS, wdata);
            cfg_write(CFG_BLOCK_SIZE, CFG_DATA_W'(ph_bs[p]));
            src_idle_pct  = ph_src[p];
            snk_stall_pct = ph_snk[p];

            // every phase opens with a fresh map
            send_req(OP_INIT, IDX_W'($urandom_range(1023)), CNT_W'($urandom_range(2047)),
                     1'b0, '0);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                if (p == 0 && j == 30)
                    rx_hold_reqs++;   // back-pressure while requests keep coming
                if (p == 1 && j == 50) begin
                    i_s_axis_tvalid <= 1'b0;
                    wait_drained();
                end
                random_req(op, idx, cnt);
                send_req(op, idx, cnt, 1'b0, '0);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests across %0d register writes: %0d runs placed,",
                 n_requests, n_cfg_writes, n_placed);
        $display("%0d allocations refused for space, %0d requests rejected as out of range.",
                 n_refused, n_rejected);
        if (n_mismatch == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
design/bcba_pkg.sv
design/bcba_div.sv
design/bitmap_contiguous_block_allocator_core.sv
tb/tb.sv
